>>> hw/rtl/jacobi_poisson_relaxation_top_macros.svh
// Assertion helpers shared by the RTL.
`ifndef JACOBI_POISSON_RELAXATION_TOP_MACROS_SVH
`define JACOBI_POISSON_RELAXATION_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define JPR_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define JPR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/jpr_pkg.sv
`timescale 1ns / 1ps
package jpr_pkg;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SWEEPS = 2'd2;

  // Input item fields.
  typedef struct packed {
    logic signed [31:0] rhs_value;
    logic signed [31:0] cell_value;
    logic [11:0]        cell_index;
    logic [1:0]         operation;
  } in_item_t;
endpackage

>>> hw/rtl/jpr_ram.sv
`timescale 1ns / 1ps
module jpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/jacobi_poisson_relaxation_top.sv
`timescale 1ns / 1ps
// Channel   | Direction | Contents
// s_axis    | in        | tdata: operation, cell_index, cell_value, rhs_value
// m_axis    | out       | tdata: read_value; tuser: index_error
// apb       | in/out    | grid_width, grid_height, sweep_count
//
// A load, an unused operation code or a run with sweep_count 0 is answered in
// the output register at its accepting edge, so such requests can follow back to
// back. A read goes through the registered memory read before the output
// register, and the next request waits while the read is pending. A run sweeps
// every cell in the FETCH, DRAIN and WRITE states and posts its result from
// the DONE state. An interior cell needs five reads through the single read
// address shared by the banks and the right-hand-side store, then waits in DRAIN
// for the last data and writes in WRITE; a border cell reads only its own value,
// which passes through. The input stalls for the whole run.
// Reset is synchronous and only clears control state; the memories are not
// cleared. The output register holds a result while tready is low, and the input
// stalls until it is taken.
module jacobi_poisson_relaxation_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [13:2] cell_index, [45:14] cell_value, [77:46] rhs_value
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] read_value
  output logic [31:0]  m_axis_tdata,
  // [0] index_error
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import jpr_pkg::*;
  `include "jacobi_poisson_relaxation_top_macros.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int VB    = VALUE_BITS;
  localparam int SB    = VB + 3;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Configuration registers.
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [9:0] sweep_count;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      sweep_count <= 10'd20;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  grid_width  <= pwdata[6:0];
        REG_HEIGHT: grid_height <= pwdata[6:0];
        REG_SWEEPS: sweep_count <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, grid_width};
      REG_HEIGHT: prdata = {25'd0, grid_height};
      REG_SWEEPS: prdata = {22'd0, sweep_count};
      default:    prdata = 32'd0;
    endcase
  end

  // Clamped grid size.
  logic [CW-1:0] w_use;
  logic [RW-1:0] h_use;
  logic [AW:0]   cells;
  always_comb begin
    if (grid_width < 7'd3) w_use = CW'(3);
    else if (32'(grid_width) > MAX_WIDTH) w_use = CW'(MAX_WIDTH);
    else w_use = CW'(grid_width);
    if (grid_height < 7'd3) h_use = RW'(3);
    else if (32'(grid_height) > MAX_HEIGHT) h_use = RW'(MAX_HEIGHT);
    else h_use = RW'(grid_height);
  end
  assign cells = (AW+1)'(w_use) * (AW+1)'(h_use);

  in_item_t in_item;
  assign in_item = in_item_t'(s_axis_tdata[77:0]);

  // Memories. A single read address is shared by all three; bank writes go
  // to the bank that is loaded or swept into.
  logic          cur_bank;
  logic          a_we, b_we, r_we;
  logic [AW-1:0] waddr, raddr;
  logic [VB-1:0] wdata, a_q, b_q, r_q;

  jpr_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_bank_a (
    .clk(clk), .we(a_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(a_q));
  jpr_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_bank_b (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(b_q));
  jpr_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_rhs (
    .clk(clk), .we(r_we), .waddr(waddr), .wdata(VB'(in_item.rhs_value)),
    .raddr(raddr), .rdata(r_q));

  // Sweep sequencer state.
  logic [2:0]    state;
  logic [9:0]    sweeps_left;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] cell_addr;
  logic [2:0]    tap;       // read issued this cycle
  logic [2:0]    tap_q;     // read whose data arrives this cycle
  logic          tap_v;
  logic signed [SB-1:0] acc;
  logic          border;

  // Output stage and read pipeline.
  logic          rd_pend;
  logic          rd_err;
  logic          out_v;
  logic          out_busy;

  assign out_busy      = out_v && !m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !out_busy && !rd_pend;
  assign m_axis_tvalid = out_v;
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  logic idx_bad;
  assign idx_bad = {1'b0, in_item.cell_index} >= 13'(cells);
  logic run_start;
  assign run_start = acc_in && in_item.operation == OP_RUN && sweep_count != 10'd0;

  // A result enters the output register after a read, at a request that needs
  // no memory read or sweep, or once a run has finished and the register is free.
  logic out_set;
  assign out_set = rd_pend || (acc_in && in_item.operation != OP_READ && !run_start) ||
                   (state == ST_DONE && !out_busy);

  assign border = (row == '0) || (col == '0) || (row == h_use - 1'b1) ||
                  (col == w_use - 1'b1);

  // Tap order: 0 self/rhs, 1 left, 2 right, 3 up, 4 down.
  always_comb begin
    raddr = AW'(in_item.cell_index);
    if (state == ST_FETCH) begin
      case (tap)
        3'd0:    raddr = cell_addr;
        3'd1:    raddr = cell_addr - 1'b1;
        3'd2:    raddr = cell_addr + 1'b1;
        3'd3:    raddr = cell_addr - AW'(w_use);
        default: raddr = cell_addr + AW'(w_use);
      endcase
    end
  end

  logic [VB-1:0] src_q;
  assign src_q = cur_bank ? b_q : a_q;

  // Saturate and quarter the accumulated sum.
  logic signed [SB-1:0] sat;
  logic [VB-1:0] relaxed;
  always_comb begin
    if (acc > SB'($signed({1'b0, {(VB-1){1'b1}}})))
      sat = SB'($signed({1'b0, {(VB-1){1'b1}}}));
    else if (acc < SB'($signed({1'b1, {(VB-1){1'b0}}})))
      sat = SB'($signed({1'b1, {(VB-1){1'b0}}}));
    else sat = acc;
    relaxed = VB'(sat >>> 2);
  end

  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    r_we  = 1'b0;
    waddr = AW'(in_item.cell_index);
    wdata = VB'(in_item.cell_value);
    if (state == ST_WRITE) begin
      waddr = cell_addr;
      wdata = border ? VB'(acc) : relaxed;
      a_we  = cur_bank;
      b_we  = !cur_bank;
    end else if (acc_in && in_item.operation == OP_LOAD && !idx_bad) begin
      a_we = !cur_bank;
      b_we = cur_bank;
      r_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur_bank <= 1'b0;
      tap_v <= 1'b0;
      rd_pend <= 1'b0;
      out_v <= 1'b0;
    end else begin
      tap_v   <= (state == ST_FETCH);
      tap_q   <= tap;
      rd_pend <= acc_in && in_item.operation == OP_READ;
      rd_err  <= idx_bad;
      out_v   <= out_set || out_busy;
      if (rd_pend) begin
        m_axis_tdata <= rd_err ? 32'd0 : 32'($signed(src_q));
        m_axis_tuser <= rd_err;
      end
      case (state)
        ST_IDLE: begin
          if (run_start) begin
            state <= ST_FETCH;
            sweeps_left <= sweep_count;
            row <= '0; col <= '0; cell_addr <= '0; tap <= 3'd0;
          end else if (acc_in && in_item.operation != OP_READ) begin
            m_axis_tdata <= 32'd0;
            m_axis_tuser <= idx_bad && in_item.operation == OP_LOAD;
          end
        end
        ST_FETCH: begin
          if (border || tap == 3'd4) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          tap <= 3'd0;
          if (col == w_use - 1'b1) begin
            col <= '0;
            if (row == h_use - 1'b1) begin
              row <= '0;
              cell_addr <= '0;
              cur_bank <= !cur_bank;
              sweeps_left <= sweeps_left - 1'b1;
              state <= (sweeps_left == 10'd1) ? ST_DONE : ST_FETCH;
            end else begin
              row <= row + 1'b1;
              cell_addr <= cell_addr + 1'b1;
              state <= ST_FETCH;
            end
          end else begin
            col <= col + 1'b1;
            cell_addr <= cell_addr + 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          // The run's request is answered once the output register is free.
          if (!out_busy) begin
            m_axis_tdata <= 32'd0;
            m_axis_tuser <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Accumulate as the tap data returns; the border value passes through.
  always_ff @(posedge clk) begin
    if (tap_v) begin
      if (tap_q == 3'd0) begin
        acc <= border ? SB'($signed(src_q)) : SB'($signed(r_q));
      end else begin
        acc <= acc + SB'($signed(src_q));
      end
    end
  end

  `JPR_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !s_axis_tready)
  `JPR_ASSERT_IMP(a_one_bank_write, clk, rst, 1'b1, !(a_we && b_we))
  `JPR_ASSERT_NEXT(a_read_result, clk, rst, rd_pend, out_v)
endmodule
